### rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int FUNC_W   = 2;
   localparam int BYTES_W  = 16;
   localparam int ADDR_W   = 14;
   localparam int STATUS_W = 2;

   localparam int DEF_HEAP_GRANULES = 1024;
   localparam int DEF_GRANULE_BYTES = 16;

   typedef enum logic [FUNC_W-1:0] {
      FN_ALLOC   = 2'd0,
      FN_RELEASE = 2'd1,
      FN_RESIZE  = 2'd2,
      FN_CLEAR   = 2'd3
   } func_type;

   localparam logic [STATUS_W-1:0] STAT_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_OOM = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD = 2'd2;

   // null and zero-size token data offsets
   localparam logic [ADDR_W-1:0] ADDR_NULL  = 14'd0;
   localparam logic [ADDR_W-1:0] ADDR_TOKEN = 14'd1;

endpackage

### rtl/ffha_mem.sv
// ----------------------------------------------------------------------------
// ffha_mem
// Block header table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffha_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit block bookkeeping over a heap of granules with one-granule headers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_func, req_bytes, req_data_addr
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_result_addr, rsp_status
//
//  One transaction at a time. Each header visit of a chain walk is a read, then a
//  decide, on the single header table port; a merge step is likewise a read, then a
//  decide with a write, a split two writes. Resize can take a walk to the block, a
//  merge pass, a full walk and another merge pass.
//  Reset empties the heap at once (break to zero); the table needs no clearing.
//  A finished result waits in the output register while rsp_ready is low.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
   parameter int HEAP_GRANULES = ffha_pkg::DEF_HEAP_GRANULES,
   parameter int GRANULE_BYTES = ffha_pkg::DEF_GRANULE_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffha_pkg::FUNC_W-1:0]   req_func,
   input  logic [ffha_pkg::BYTES_W-1:0]  req_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_data_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_result_addr,
   output logic [ffha_pkg::STATUS_W-1:0] rsp_status
);
   import ffha_pkg::*;

   localparam int IW  = $clog2(HEAP_GRANULES);
   localparam int GW  = IW + 1;
   localparam int DW  = GW + 1;
   localparam int NW  = BYTES_W + 1;
   localparam int CW  = ((GW > NW) ? GW : NW) + 2;
   localparam int AFW = ((GW + 7) > ADDR_W) ? (GW + 7) : ADDR_W;
   // ceil(x / GRANULE_BYTES) by reciprocal multiply; exact for x below 2^17
   localparam int SH    = 24;
   localparam int RW    = NW + SH;
   localparam longint RECIP = ((64'd1 << SH) + GRANULE_BYTES - 1) / GRANULE_BYTES;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_W_RD, S_W_CHK, S_W_END, S_SPLIT, S_SPLIT2,
      S_MK_RD, S_MK_WR, S_MG_START, S_MG_LOAD, S_MG_CHK, S_MG_DO,
      S_RZ_RD, S_RZ_CHK, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      K_ALLOC, K_RSZ_ALLOC, K_REL, K_RSZ
   } kind_type;

   state_type           state_ff;
   kind_type            kind_ff;
   func_type            func_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [NW-1:0]       need_ff;
   logic [GW-1:0]       brk_ff;
   logic [GW-1:0]       b_ff;
   logic [GW-1:0]       n_ff;
   logic [GW-1:0]       raw_ff;
   logic                f_ff;
   logic [GW-1:0]       tb_ff;
   logic [GW-1:0]       tn_ff;
   logic                tf_ff;
   logic [ADDR_W-1:0]   res_ff;
   logic [STATUS_W-1:0] st_ff;
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [DW-1:0] rd_data;
   logic [GW-1:0] rd_next;
   logic          rd_free;

   logic [GW-1:0]  succ_base;
   logic [GW-1:0]  succ_q;
   logic [GW-1:0]  aidx;
   logic [AFW-1:0] addr_full;
   logic [CW-1:0]  need_c;
   logic [CW-1:0]  b_need1;
   logic [CW-1:0]  tb_need1;
   logic           alloc_fit;
   logic           split_ok;
   logic [GW-1:0]  split_p;
   logic           sfree;
   logic           oom;
   logic [GW-1:0]  new_brk;
   logic           merge_pair;
   logic [RW-1:0]  need_prod;
   logic           accept;
   logic           rsp_load;

   ffha_mem #(.DEPTH(HEAP_GRANULES), .AW(IW), .DW(DW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_next = rd_data[DW-1:1];
   assign rd_free = rd_data[0];

   // successor of the header just read, clamped to the break
   always_comb begin
      case (state_ff)
         S_MK_WR:  succ_base = tb_ff;
         S_MG_DO:  succ_base = n_ff;
         S_RZ_CHK: succ_base = tn_ff;
         default:  succ_base = b_ff;
      endcase
      succ_q = ((rd_next <= succ_base) || (rd_next > brk_ff)) ? brk_ff : rd_next;
   end

   // shared data-offset multiply
   assign aidx      = (state_ff == S_W_END) ? brk_ff : b_ff;
   assign addr_full = AFW'((AFW'(aidx) + AFW'(1)) * AFW'(GRANULE_BYTES));

   assign need_c   = CW'(need_ff);
   assign b_need1  = CW'(b_ff) + need_c + CW'(1);
   assign tb_need1 = CW'(tb_ff) + need_c + CW'(1);
   assign alloc_fit = rd_free && (CW'(succ_q) >= b_need1);
   assign split_ok  = CW'(n_ff) >= (b_need1 + CW'(1));
   assign split_p   = GW'(b_need1);
   assign sfree     = ((kind_ff == K_ALLOC) || (kind_ff == K_RSZ_ALLOC)) ? 1'b0 : tf_ff;
   assign oom       = (CW'(brk_ff) + need_c + CW'(1)) > CW'(HEAP_GRANULES);
   assign new_brk   = GW'(CW'(brk_ff) + need_c + CW'(1));
   assign merge_pair = f_ff && rd_free;

   assign need_prod = RW'(RW'(req_bytes) + RW'(GRANULE_BYTES - 1)) * RW'(RECIP);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = b_ff[IW-1:0];
      case (state_ff)
         S_W_RD, S_MG_START: rd_en = 1'b1;
         S_MK_RD: begin
            rd_en   = 1'b1;
            rd_addr = tb_ff[IW-1:0];
         end
         S_MG_CHK: begin
            rd_en   = 1'b1;
            rd_addr = n_ff[IW-1:0];
         end
         S_RZ_RD: begin
            rd_en   = 1'b1;
            rd_addr = tn_ff[IW-1:0];
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = b_ff[IW-1:0];
      wr_data = {raw_ff, sfree};
      case (state_ff)
         S_W_END: begin
            wr_en   = ((kind_ff == K_ALLOC) || (kind_ff == K_RSZ_ALLOC)) && !oom;
            wr_addr = brk_ff[IW-1:0];
            wr_data = {new_brk, 1'b0};
         end
         S_SPLIT: begin
            wr_en = 1'b1;
            if (split_ok) begin
               wr_addr = split_p[IW-1:0];
               wr_data = {n_ff, 1'b1};
            end
         end
         S_SPLIT2: begin
            wr_en   = 1'b1;
            wr_data = {split_p, sfree};
         end
         S_MK_WR: begin
            wr_en   = 1'b1;
            wr_addr = tb_ff[IW-1:0];
            wr_data = {rd_next, 1'b1};
         end
         S_MG_DO: begin
            wr_en   = merge_pair;
            wr_data = {succ_q, 1'b1};
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         brk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_addr_ff   <= res_ff;
            rsp_status_ff <= st_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  func_ff  <= func_type'(req_func);
                  bytes_ff <= req_bytes;
                  addr_ff  <= req_data_addr;
                  need_ff  <= need_prod[SH +: NW];
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               res_ff <= ADDR_NULL;
               st_ff  <= STAT_OK;
               b_ff   <= '0;
               case (func_ff)
                  FN_CLEAR: begin
                     brk_ff   <= '0;
                     state_ff <= S_DONE;
                  end
                  FN_RELEASE: begin
                     kind_ff  <= K_REL;
                     state_ff <= ((addr_ff == ADDR_NULL) || (addr_ff == ADDR_TOKEN)) ?
                                 S_DONE : S_W_RD;
                  end
                  FN_RESIZE: begin
                     if (addr_ff == ADDR_NULL) begin
                        kind_ff <= K_ALLOC;
                        if (bytes_ff == '0) begin
                           res_ff   <= ADDR_TOKEN;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_W_RD;
                        end
                     end else if (bytes_ff == '0) begin
                        kind_ff  <= K_REL;
                        state_ff <= (addr_ff == ADDR_TOKEN) ? S_DONE : S_W_RD;
                     end else begin
                        kind_ff  <= K_RSZ;
                        state_ff <= S_W_RD;
                     end
                  end
                  default: begin
                     kind_ff <= K_ALLOC;
                     if (bytes_ff == '0) begin
                        res_ff   <= ADDR_TOKEN;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_W_RD;
                     end
                  end
               endcase
            end
            S_W_RD: begin
               state_ff <= (b_ff >= brk_ff) ? S_W_END : S_W_CHK;
            end
            S_W_CHK: begin
               if ((kind_ff == K_ALLOC) || (kind_ff == K_RSZ_ALLOC)) begin
                  if (alloc_fit) begin
                     n_ff     <= succ_q;
                     raw_ff   <= rd_next;
                     state_ff <= S_SPLIT;
                  end else begin
                     b_ff     <= succ_q;
                     state_ff <= S_W_RD;
                  end
               end else if (addr_full == AFW'(addr_ff)) begin
                  tb_ff  <= b_ff;
                  tf_ff  <= rd_free;
                  raw_ff <= rd_next;
                  tn_ff  <= succ_q;
                  if (kind_ff == K_REL) begin
                     state_ff <= S_MK_RD;
                  end else if (CW'(succ_q) >= b_need1) begin
                     // shrink or fit in place
                     n_ff     <= succ_q;
                     state_ff <= S_SPLIT;
                  end else begin
                     b_ff     <= succ_q;
                     state_ff <= S_MG_START;
                  end
               end else begin
                  b_ff     <= succ_q;
                  state_ff <= S_W_RD;
               end
            end
            S_W_END: begin
               if ((kind_ff == K_ALLOC) || (kind_ff == K_RSZ_ALLOC)) begin
                  if (oom) begin
                     res_ff   <= ADDR_NULL;
                     st_ff    <= STAT_OOM;
                     state_ff <= S_DONE;
                  end else begin
                     res_ff   <= addr_full[ADDR_W-1:0];
                     brk_ff   <= new_brk;
                     state_ff <= (kind_ff == K_RSZ_ALLOC) ? S_MK_RD : S_DONE;
                  end
               end else begin
                  st_ff    <= STAT_BAD;
                  state_ff <= S_DONE;
               end
            end
            S_SPLIT: begin
               res_ff <= addr_full[ADDR_W-1:0];
               if (split_ok) begin
                  state_ff <= S_SPLIT2;
               end else begin
                  state_ff <= (kind_ff == K_RSZ_ALLOC) ? S_MK_RD : S_DONE;
               end
            end
            S_SPLIT2: begin
               state_ff <= (kind_ff == K_RSZ_ALLOC) ? S_MK_RD : S_DONE;
            end
            S_MK_RD: begin
               state_ff <= S_MK_WR;
            end
            S_MK_WR: begin
               b_ff     <= tb_ff;
               f_ff     <= 1'b1;
               n_ff     <= succ_q;
               state_ff <= S_MG_CHK;
            end
            S_MG_START: begin
               if (b_ff >= brk_ff) begin
                  state_ff <= (kind_ff == K_RSZ) ? S_RZ_RD : S_DONE;
               end else begin
                  state_ff <= S_MG_LOAD;
               end
            end
            S_MG_LOAD: begin
               f_ff     <= rd_free;
               n_ff     <= succ_q;
               state_ff <= S_MG_CHK;
            end
            S_MG_CHK: begin
               if (n_ff == brk_ff) begin
                  state_ff <= (kind_ff == K_RSZ) ? S_RZ_RD : S_DONE;
               end else begin
                  state_ff <= S_MG_DO;
               end
            end
            S_MG_DO: begin
               // a merged pair stays put, otherwise step to the successor
               if (!merge_pair) begin
                  b_ff <= n_ff;
                  f_ff <= rd_free;
               end
               n_ff     <= succ_q;
               state_ff <= S_MG_CHK;
            end
            S_RZ_RD: begin
               if (tn_ff == brk_ff) begin
                  kind_ff  <= K_RSZ_ALLOC;
                  b_ff     <= '0;
                  state_ff <= S_W_RD;
               end else begin
                  state_ff <= S_RZ_CHK;
               end
            end
            S_RZ_CHK: begin
               if (rd_free && (CW'(succ_q) >= tb_need1)) begin
                  // absorb the free successor, then split
                  b_ff     <= tb_ff;
                  n_ff     <= succ_q;
                  raw_ff   <= succ_q;
                  state_ff <= S_SPLIT;
               end else begin
                  kind_ff  <= K_RSZ_ALLOC;
                  b_ff     <= '0;
                  state_ff <= S_W_RD;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;
endmodule

### rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the first-fit heap allocator.
// ----------------------------------------------------------------------------
module ffha_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ffha_pkg::ADDR_W-1:0]   rsp_result_addr,
   input logic [ffha_pkg::STATUS_W-1:0] rsp_status
);
   import ffha_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_addr)
                                  && $stable(rsp_status))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_OOM)
                    || (rsp_status == STAT_BAD))
      else $error("undefined status code");

   // errors never hand out an address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_result_addr == ADDR_NULL)
      else $error("address returned with error status");

   // one transaction in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_addr (rsp_result_addr),
   .rsp_status      (rsp_status)
);
